### hdl/acc_tilt_pkg.sv
// Shared types and constants for the accelerometer tilt angle pipeline.
package acc_tilt_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_ITERS = 18;
    localparam int INT_FRAC     = 16;
    localparam int CW           = 36;
    localparam int ZW           = 25;

    localparam logic signed [14:0] OFFSET_RESET = 15'sd909;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
        25'sd3667, 25'sd1833, 25'sd917, 25'sd458, 25'sd229, 25'sd115,
        25'sd57, 25'sd29
    };

    typedef struct packed {
        logic [34:0]        rem;
        logic [31:0]        root;
        logic [31:0]        rad;
        logic signed [15:0] ax;
        logic               zero;
    } sqrt_data_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_data_t;

endpackage

### hdl/accel_tilt_angle.sv
// Top level of the accelerometer tilt angle pipeline.
//
// An accelerometer word (accel_x, accel_y, accel_z) enters on the input
// channel with in_valid/in_ready, and one tilt_angle word leaves on the
// output channel with out_valid/out_ready. The angle is
// atan2(x, sqrt(y*y + z*z)) in degrees, scaled by 2^ANGLE_FRAC_BITS, minus
// the calibration offset written through cfg_we/cfg_wdata.
// The datapath is a 52-stage pipeline: one stage of squares, 32 square
// root stages (one root bit each), 18 CORDIC vectoring stages and one
// rounding, offset and saturation stage. The block takes one word every
// cycle while the receiver does not stall.
// All stages advance together; when the output word is held by a low
// out_ready, the whole pipeline freezes and in_ready drops, so nothing is
// lost or repeated. Bubbles are not squeezed out: an empty stage freezes
// along with the full ones while the output word waits.
// Reset clears every valid bit and loads the offset with 909.
module accel_tilt_angle #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] tilt_angle,
    input  logic               cfg_we,
    input  logic signed [14:0] cfg_wdata
);

    localparam int SQ  = acc_tilt_pkg::SQRT_STEPS;
    localparam int CI  = acc_tilt_pkg::CORDIC_ITERS;
    localparam int ZW  = acc_tilt_pkg::ZW;
    localparam int RSH = acc_tilt_pkg::INT_FRAC - ANGLE_FRAC_BITS;

    logic                       advance;
    logic                       sq_vld [SQ+1];
    acc_tilt_pkg::sqrt_data_t   sq_data [SQ+1];
    logic                       co_vld [CI+1];
    acc_tilt_pkg::cordic_data_t co_data [CI+1];

    logic signed [14:0]         offset_reg;
    logic signed [ZW-1:0]       z_final;
    logic signed [ZW-1:0]       angle;
    logic signed [ZW:0]         diff;
    logic signed [15:0]         tilt_next;
    logic signed [15:0]         tilt_reg;
    logic                       out_vld_reg;

    // The pipeline moves whenever the output register is free or emptying.
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= acc_tilt_pkg::OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            offset_reg <= cfg_wdata;
        end
    end

    acc_tilt_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_vld   (in_valid),
        .ax       (accel_x),
        .ay       (accel_y),
        .az       (accel_z),
        .out_vld  (sq_vld[0]),
        .out_data (sq_data[0])
    );

    // Square root of (y*y + z*z) * 2^32, one result bit per stage.
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        acc_tilt_sqrt_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .in_vld   (sq_vld[k]),
            .in_data  (sq_data[k]),
            .out_vld  (sq_vld[k+1]),
            .out_data (sq_data[k+1])
        );
    end

    // The CORDIC starts from the magnitude and x scaled to 16 fraction bits.
    always_comb
    begin
        co_vld[0]       = sq_vld[SQ];
        co_data[0].x    = signed'({4'b0000, sq_data[SQ].root});
        co_data[0].y    = {{4{sq_data[SQ].ax[15]}}, sq_data[SQ].ax, 16'h0000};
        co_data[0].z    = '0;
        co_data[0].zero = sq_data[SQ].zero;
    end

    for (genvar i = 0; i < CI; i++)
    begin : g_cordic
        acc_tilt_cordic_stage #(
            .ITER (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .in_vld   (co_vld[i]),
            .in_data  (co_data[i]),
            .out_vld  (co_vld[i+1]),
            .out_data (co_data[i+1])
        );
    end

    // An all-zero sample has no direction, so its angle is forced to zero before the offset is subtracted.
    assign z_final = co_data[CI].zero ? '0 : co_data[CI].z;

    if (RSH > 0)
    begin : g_round
        localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (RSH - 1);
        assign angle = (z_final + HALF) >>> RSH;
    end
    else
    begin : g_noround
        assign angle = z_final;
    end

    always_comb
    begin
        diff = {angle[ZW-1], angle} - (ZW+1)'(offset_reg);
        if (diff > (ZW+1)'(32767))
        begin
            tilt_next = 16'sh7fff;
        end
        else if (diff < -(ZW+1)'(32768))
        begin
            tilt_next = 16'sh8000;
        end
        else
        begin
            tilt_next = diff[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= co_vld[CI];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tilt_reg <= tilt_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign tilt_angle = tilt_reg;

endmodule

### hdl/acc_tilt_square.sv
// First pipeline stage: squares of y and z and the all-zero detect.
module acc_tilt_square (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic signed [15:0]       ax,
    input  logic signed [15:0]       ay,
    input  logic signed [15:0]       az,
    output logic                     out_vld,
    output acc_tilt_pkg::sqrt_data_t out_data
);

    logic signed [31:0]       yy;
    logic signed [31:0]       zz;
    acc_tilt_pkg::sqrt_data_t data_next;
    acc_tilt_pkg::sqrt_data_t data_reg;
    logic                     vld_reg;

    always_comb
    begin
        yy             = ay * ay;
        zz             = az * az;
        data_next.rem  = '0;
        data_next.root = '0;
        data_next.rad  = unsigned'(yy) + unsigned'(zz);
        data_next.ax   = ax;
        data_next.zero = (ax == 16'sd0) && (ay == 16'sd0) && (az == 16'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

### hdl/acc_tilt_sqrt_stage.sv
// One digit-by-digit square root step, producing one root bit per stage.
module acc_tilt_sqrt_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_vld,
    input  acc_tilt_pkg::sqrt_data_t in_data,
    output logic                     out_vld,
    output acc_tilt_pkg::sqrt_data_t out_data
);

    logic [34:0]              rem_sh;
    logic [34:0]              trial;
    acc_tilt_pkg::sqrt_data_t data_next;
    acc_tilt_pkg::sqrt_data_t data_reg;
    logic                     vld_reg;

    always_comb
    begin
        rem_sh    = {in_data.rem[32:0], in_data.rad[31:30]};
        trial     = {1'b0, in_data.root, 2'b01};
        data_next = in_data;
        data_next.rad = {in_data.rad[29:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {in_data.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {in_data.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

### hdl/acc_tilt_cordic_stage.sv
// One CORDIC vectoring iteration with its fixed shift and angle constant.
module acc_tilt_cordic_stage #(
    parameter int ITER = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  acc_tilt_pkg::cordic_data_t in_data,
    output logic                       out_vld,
    output acc_tilt_pkg::cordic_data_t out_data
);

    logic signed [acc_tilt_pkg::CW-1:0] dx;
    logic signed [acc_tilt_pkg::CW-1:0] dy;
    acc_tilt_pkg::cordic_data_t         data_next;
    acc_tilt_pkg::cordic_data_t         data_reg;
    logic                               vld_reg;

    always_comb
    begin
        dx        = in_data.y >>> ITER;
        dy        = in_data.x >>> ITER;
        data_next = in_data;
        if (!in_data.y[acc_tilt_pkg::CW-1])
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + acc_tilt_pkg::ATAN_TAB[ITER];
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - acc_tilt_pkg::ATAN_TAB[ITER];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

### hdl/acc_tilt_checker.sv
// Port-level checks for the tilt angle pipeline and their binding.
module acc_tilt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] tilt_angle
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word present during reset");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not track the output register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tilt_angle))
        else $error("stalled output word changed or vanished");

endmodule

bind accel_tilt_angle acc_tilt_checker u_acc_tilt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tilt_angle (tilt_angle)
);

### bench/accel_tilt_angle_tb.sv
// Self-checking testbench for the accelerometer tilt angle pipeline.
module accel_tilt_angle_tb;

    localparam int FRAC_BITS        = 8;
    localparam int PIPE_LATENCY     = 52;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int HOLD_CYCLES      = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] tilt_angle;
    logic               cfg_we;
    logic signed [14:0] cfg_wdata;

    // Expected angles, oldest first, and the bench's copy of the offset.
    logic signed [15:0] angle_queue[$];
    logic signed [14:0] offset_copy;

    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int quiet_cycles;

    accel_tilt_angle #(
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tilt_angle(tilt_angle),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Integer square root of a 64-bit value, one result bit per pass.
    function automatic longint unsigned isqrt64(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Computes the calibrated tilt angle of one sample: square root of the
    // y/z magnitude, CORDIC vectoring against x, rounding, offset and saturation.
    function automatic logic signed [15:0] predict_tilt(logic signed [15:0] ax,
                                                        logic signed [15:0] ay,
                                                        logic signed [15:0] az);
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          a;
        longint unsigned s;
        z = 0;
        s = longint'(ay) * longint'(ay) + longint'(az) * longint'(az);
        if (ax != 0 || s != 0)
        begin
            x = longint'(isqrt64(s << 32));
            y = longint'(ax) * 65536;
            for (int i = 0; i < acc_tilt_pkg::CORDIC_ITERS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(acc_tilt_pkg::ATAN_TAB[i]);
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(acc_tilt_pkg::ATAN_TAB[i]);
                end
            end
        end
        // Round to nearest with ties toward plus infinity.
        a = (z + (64'sd1 <<< (acc_tilt_pkg::INT_FRAC - FRAC_BITS - 1)))
            >>> (acc_tilt_pkg::INT_FRAC - FRAC_BITS);
        a = a - longint'(offset_copy);
        if (a > 32767)
            a = 32767;
        if (a < -32768)
            a = -32768;
        return a[15:0];
    endfunction

    // Offers one sample word, with a random lead-in gap, and records the
    // expected angle at the edge where the block accepts it.
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= ax;
        accel_y  <= ay;
        accel_z  <= az;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        angle_queue.push_back(predict_tilt(ax, ay, az));
        @(negedge clk);
    endtask

    // Waits until every expected angle has come out, then lets the pipeline
    // run empty so that a register write cannot land on a word in flight.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(negedge clk);
        while (angle_queue.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_offset(logic signed [14:0] value);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        offset_copy  = value;
    endtask

    function automatic logic signed [15:0] random_axis();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return 16'($urandom());
        else if (pick < 75)
            return $signed(16'($urandom_range(8))) - 16'sd4;
        else if (pick < 90)
            return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else
            return $signed(16'($urandom_range(16383))) - 16'sd8192;
    endfunction

    // Extremes of each axis and the named special cases: the all-zero
    // sample, samples with only x set, and samples with x zero.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sh7fff, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0, 16'sd0);
        send_sample(-16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sh7fff, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sh8000);
        send_sample(16'sd0, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_sample(16'sd1, 16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd16384, 16'sd0, 16'sd16384);
        send_sample(-16'sd16384, 16'sd16384, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd16384);
        send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
    endtask

    // Runs a few samples under each offset setting, the reset value included.
    task automatic test_offsets();
        logic signed [14:0] settings[5];
        settings = '{-15'sd8192, 15'sd8192, 15'sd0, -15'sd1,
                     acc_tilt_pkg::OFFSET_RESET};
        foreach (settings[k])
        begin
            write_offset(settings[k]);
            send_sample(16'sh7fff, 16'sd0, 16'sd0);
            send_sample(16'sh8000, 16'sd0, 16'sd0);
            send_sample(16'sd0, 16'sd0, 16'sd0);
            send_sample(random_axis(), random_axis(), random_axis());
        end
    endtask

    task automatic test_random(int count, int snd_pct, int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_offset($signed(15'($urandom_range(16384))) - 15'sd8192);
        repeat (count)
            send_sample(random_axis(), random_axis(), random_axis());
    endtask

    // The receiver stops for a long stretch while samples keep coming, so
    // the pipeline fills and the input side has to stall.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        repeat (120)
            send_sample(random_axis(), random_axis(), random_axis());
    endtask

    // Receiver: random stalls, plus the long hold when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares each output word with the oldest expected angle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (angle_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected tilt_angle %0d", $time, tilt_angle);
            end
            else
            begin
                if (tilt_angle !== angle_queue[0])
                begin
                    errors++;
                    $display("%0t: tilt_angle expected %0d actual %0d",
                             $time, angle_queue[0], tilt_angle);
                end
                void'(angle_queue.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("accel_tilt_angle regression: fail");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        quiet_cycles  = 0;
        hold_left     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offset_copy   = acc_tilt_pkg::OFFSET_RESET;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        accel_x       = '0;
        accel_y       = '0;
        accel_z       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first samples run with the offset as it comes out of reset.
        test_directed();
        test_offsets();
        test_random(500, 11, 78);
        test_random(500, 78, 11);
        test_backpressure();
        test_random(500, 0, 0);

        drain_pipeline();
        if (errors == 0)
            $display("accel_tilt_angle regression: pass");
        else
            $display("accel_tilt_angle regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/acc_tilt_pkg.sv
hdl/acc_tilt_square.sv
hdl/acc_tilt_sqrt_stage.sv
hdl/acc_tilt_cordic_stage.sv
hdl/accel_tilt_angle.sv
hdl/acc_tilt_checker.sv
bench/accel_tilt_angle_tb.sv
